// ----- rtl/pic_pkg.sv -----
// shared types and constants of the priority interrupt controller
// no dependencies; imported by the interfaces and every module
package pic_pkg;

  // number of interrupt levels, 2 .. 15
  localparam int unsigned LEVELS = 8;

  // field widths fixed by the external word format
  localparam int unsigned OPC_W  = 1;
  localparam int unsigned LVL_W  = 4;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned MASK_W = 8;

  // stack occupancy counter and stack index
  localparam int unsigned CNT_W = $clog2(LEVELS + 1);
  localparam int unsigned IDX_W = $clog2(LEVELS);

  localparam logic [OPC_W-1:0] OP_REQ = 1'b0;
  localparam logic [OPC_W-1:0] OP_END = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_HELD  = 2'd0,
    KIND_START = 2'd1,
    KIND_END   = 2'd2,
    KIND_ERR   = 2'd3
  } kind_e;

  typedef enum logic {
    ST_IDLE,
    ST_SECOND
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic exec;   // run the accepted word
    logic start;  // start the level found on end of service
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic has_result;   // accepted word yields a result
    logic need_second;  // end of service found a pending level
  } dp_status_t;

endpackage

// ----- rtl/pic_if.sv -----
// valid/ready channel interfaces for request and event words
// depends on pic_pkg
interface pic_req_if
  import pic_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [OPC_W-1:0] opcode;
  logic [LVL_W-1:0] level;

  modport source (output valid, output opcode, output level, input ready);
  modport sink   (input valid, input opcode, input level, output ready);
endinterface

interface pic_evt_if
  import pic_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] event_kind;
  logic [LVL_W-1:0]  event_level;
  logic [LVL_W-1:0]  current_priority;
  logic [MASK_W-1:0] pending_mask;
  logic              last;

  modport source (output valid, output event_kind, output event_level,
                  output current_priority, output pending_mask, output last,
                  input ready);
  modport sink   (input valid, input event_kind, input event_level,
                  input current_priority, input pending_mask, input last,
                  output ready);
endinterface

// ----- rtl/pic_ctrl.sv -----
// controller state machine: input handshake, output valid, datapath commands
// depends on pic_pkg
module pic_ctrl
  import pic_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  state_e state_q, state_d;
  logic   out_vld_q, out_vld_d;
  logic   slot_free;

  assign slot_free = !out_vld_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && slot_free && status_i.need_second) state_d = ST_SECOND;
      end
      ST_SECOND: begin
        if (slot_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = slot_free;
        cmd_o.exec = in_valid_i && slot_free;
      end
      ST_SECOND: begin
        cmd_o.start = slot_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
    if ((cmd_o.exec && status_i.has_result) || cmd_o.start) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  assign out_valid_o = out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

endmodule

// ----- rtl/pic_dp.sv -----
// datapath: pending bits, priority, priority stack, encoder, event register
// depends on pic_pkg
module pic_dp
  import pic_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dp_cmd_t           cmd_i,
  input  logic [OPC_W-1:0]  opcode_i,
  input  logic [LVL_W-1:0]  level_i,
  output dp_status_t        status_o,
  output logic [KIND_W-1:0] event_kind_o,
  output logic [LVL_W-1:0]  event_level_o,
  output logic [LVL_W-1:0]  current_priority_o,
  output logic [MASK_W-1:0] pending_mask_o,
  output logic              last_o
);

  logic [LEVELS-1:0] pend_q, pend_d;
  logic [LVL_W-1:0]  prio_q, prio_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [LVL_W-1:0]  stack_q [LEVELS];
  logic [LVL_W-1:0]  found_q, found_d;

  kind_e             kind_q, kind_d;
  logic [LVL_W-1:0]  evl_q, evl_d;
  logic [LVL_W-1:0]  cpr_q;
  logic [MASK_W-1:0] mask_q;
  logic              last_q, last_d;

  logic              level_ok;
  logic [LEVELS-1:0] req_bit, found_bit;
  logic [CNT_W-1:0]  cnt_dec;
  logic [LVL_W-1:0]  restored, found;
  logic              push_en, stack_room;
  logic [MASK_W+LEVELS-1:0] mask_wide;

  assign level_ok   = (level_i != '0) && (level_i <= LVL_W'(LEVELS));
  assign req_bit    = {{(LEVELS-1){1'b0}}, 1'b1} << (level_i - LVL_W'(1));
  assign found_bit  = {{(LEVELS-1){1'b0}}, 1'b1} << (found_q - LVL_W'(1));
  assign cnt_dec    = cnt_q - CNT_W'(1);
  assign restored   = stack_q[cnt_dec[IDX_W-1:0]];
  assign stack_room = cnt_q < CNT_W'(LEVELS);

  // highest pending level above the restored priority
  always_comb begin
    found = '0;
    for (int i = 0; i < LEVELS; i++) begin
      if (pend_q[i] && (LVL_W'(i + 1) > restored)) found = LVL_W'(i + 1);
    end
  end

  always_comb begin
    pend_d   = pend_q;
    prio_d   = prio_q;
    cnt_d    = cnt_q;
    found_d  = found_q;
    push_en  = 1'b0;
    kind_d   = kind_q;
    evl_d    = evl_q;
    last_d   = 1'b1;
    status_o = '0;
    if (cmd_i.start) begin
      push_en = 1'b1;
      prio_d  = found_q;
      pend_d  = pend_q & ~found_bit;
      kind_d  = KIND_START;
      evl_d   = found_q;
    end else if (opcode_i == OP_REQ) begin
      status_o.has_result = level_ok;
      evl_d = level_i;
      if (level_ok) begin
        if (level_i > prio_q) begin
          push_en = 1'b1;
          prio_d  = level_i;
          pend_d  = pend_q & ~req_bit;
          kind_d  = KIND_START;
        end else begin
          pend_d  = pend_q | req_bit;
          kind_d  = KIND_HELD;
        end
      end
    end else begin
      status_o.has_result = 1'b1;
      if (cnt_q == '0) begin
        kind_d = KIND_ERR;
        evl_d  = '0;
      end else begin
        cnt_d   = cnt_dec;
        prio_d  = restored;
        kind_d  = KIND_END;
        evl_d   = prio_q;
        found_d = found;
        last_d  = (found == '0);
        status_o.need_second = (found != '0);
      end
    end
    if (push_en && stack_room) cnt_d = cnt_q + CNT_W'(1);
  end

  assign mask_wide = {{MASK_W{1'b0}}, pend_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      prio_q <= '0;
      cnt_q  <= '0;
    end else if (cmd_i.exec || cmd_i.start) begin
      pend_q <= pend_d;
      prio_q <= prio_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((cmd_i.exec || cmd_i.start) && push_en && stack_room) begin
      stack_q[cnt_q[IDX_W-1:0]] <= prio_q;
    end
    if (cmd_i.exec) found_q <= found_d;
    if ((cmd_i.exec && status_o.has_result) || cmd_i.start) begin
      kind_q <= kind_d;
      evl_q  <= evl_d;
      cpr_q  <= prio_d;
      mask_q <= mask_wide[MASK_W-1:0];
      last_q <= last_d;
    end
  end

  assign event_kind_o       = kind_q;
  assign event_level_o      = evl_q;
  assign current_priority_o = cpr_q;
  assign pending_mask_o     = mask_q;
  assign last_o             = last_q;

endmodule

// ----- rtl/priority_interrupt_controller.sv -----
// top level of the nested priority interrupt controller
// depends on pic_pkg, pic_if, pic_ctrl and pic_dp
//
// A request word sets the pending bit of its level and, when the level is
// above the priority in force, saves that priority on an internal stack and
// starts the level at once; an end word restores the saved priority and then
// starts the highest pending level above it. Requests with level 0 or above
// the number of levels give no event word, every other word gives one event,
// and an end that starts a new level gives two (the second with last set).
// An end word that starts a pending level holds off the next word until its
// second event is loaded, since both events go out through the single
// event register; the block accepts the next word while an event still waits
// for the sink, as long as that register is taken in the same cycle.
module priority_interrupt_controller
  import pic_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  pic_req_if.sink    req_i,
  pic_evt_if.source  evt_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencing: accept, emit, second event of an end of service
  pic_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_ready_i (evt_o.ready),
    .out_valid_o (evt_o.valid),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // priority state, stack and event register
  pic_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .opcode_i           (req_i.opcode),
    .level_i            (req_i.level),
    .status_o           (status),
    .event_kind_o       (evt_o.event_kind),
    .event_level_o      (evt_o.event_level),
    .current_priority_o (evt_o.current_priority),
    .pending_mask_o     (evt_o.pending_mask),
    .last_o             (evt_o.last)
  );

endmodule

// ----- rtl/pic_checker.sv -----
// port level checks for the priority interrupt controller, with bind
// depends on pic_pkg and priority_interrupt_controller
module pic_checker
  import pic_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [KIND_W-1:0] event_kind_i,
  input logic [LVL_W-1:0]  event_level_i,
  input logic [LVL_W-1:0]  current_priority_i,
  input logic [MASK_W-1:0] pending_mask_i,
  input logic              last_i
);

  // stalled word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(event_kind_i) &&
      $stable(event_level_i) && $stable(current_priority_i) &&
      $stable(pending_mask_i) && $stable(last_i))
    else $error("event word changed while stalled");

  // error word carries level zero and ends its item
  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (event_kind_i == KIND_ERR) |-> (event_level_i == '0) && last_i)
    else $error("bad end-while-idle word");

  // a started level becomes the priority in force
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (event_kind_i == KIND_START) |->
      (current_priority_i == event_level_i) && last_i)
    else $error("started level not in force");

  // a held request is not above the priority in force
  a_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (event_kind_i == KIND_HELD) |->
      (event_level_i <= current_priority_i) && last_i)
    else $error("held request above priority");

  // first word of a pair is followed by the second at once
  a_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !last_i |=> out_valid_i)
    else $error("second event of end of service missing");

endmodule

bind priority_interrupt_controller pic_checker u_pic_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_i        (evt_o.valid),
  .out_ready_i        (evt_o.ready),
  .event_kind_i       (evt_o.event_kind),
  .event_level_i      (evt_o.event_level),
  .current_priority_i (evt_o.current_priority),
  .pending_mask_i     (evt_o.pending_mask),
  .last_i             (evt_o.last)
);

// ----- dv/priority_interrupt_controller_tb.sv -----
// testbench of the nested priority interrupt controller: directed table, then random words
// depends on pic_pkg, pic_if and the priority_interrupt_controller top level
module priority_interrupt_controller_tb;
  import pic_pkg::*;

  localparam int unsigned RAND_WORDS  = 1650;
  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned DRAIN_CYC   = 20;
  localparam int unsigned HOLD_AFTER  = 400;
  localparam int unsigned HOLD_CYC    = 300;
  localparam int unsigned DIR_N       = 25;

  typedef struct packed {
    kind_e             kind;
    logic [LVL_W-1:0]  lvl;
    logic [LVL_W-1:0]  prio;
    logic [MASK_W-1:0] mask;
    logic              last;
  } pic_evt_t;

  // one row of the directed table; typed rows carry a single expected event
  typedef struct packed {
    logic [OPC_W-1:0]  op;
    logic [LVL_W-1:0]  lvl;
    logic              typed;
    kind_e             kind;
    logic [LVL_W-1:0]  elvl;
    logic [LVL_W-1:0]  eprio;
    logic [MASK_W-1:0] emask;
  } dir_row_t;

  localparam dir_row_t DIR_TAB [DIR_N] = '{
    '{OP_END, 4'd0,  1'b1, KIND_ERR,   4'd0, 4'd0, 8'h00}, // end while idle after reset
    '{OP_REQ, 4'd0,  1'b0, KIND_HELD,  4'd0, 4'd0, 8'h00}, // level zero, ignored
    '{OP_REQ, 4'd9,  1'b0, KIND_HELD,  4'd0, 4'd0, 8'h00}, // just above the top level
    '{OP_REQ, 4'd15, 1'b0, KIND_HELD,  4'd0, 4'd0, 8'h00}, // all level bits set
    '{OP_REQ, 4'd1,  1'b1, KIND_START, 4'd1, 4'd1, 8'h00},
    '{OP_REQ, 4'd1,  1'b1, KIND_HELD,  4'd1, 4'd1, 8'h01}, // equal to priority, held
    '{OP_REQ, 4'd8,  1'b1, KIND_START, 4'd8, 4'd8, 8'h01},
    '{OP_REQ, 4'd8,  1'b1, KIND_HELD,  4'd8, 4'd8, 8'h81},
    '{OP_REQ, 4'd5,  1'b1, KIND_HELD,  4'd5, 4'd8, 8'h91},
    '{OP_END, 4'd0,  1'b0, KIND_HELD,  4'd0, 4'd0, 8'h00}, // end, then restart of 8
    '{OP_END, 4'd0,  1'b0, KIND_HELD,  4'd0, 4'd0, 8'h00}, // end, then start of 5
    '{OP_END, 4'd0,  1'b0, KIND_HELD,  4'd0, 4'd0, 8'h00}, // end with nothing above
    '{OP_END, 4'd0,  1'b0, KIND_HELD,  4'd0, 4'd0, 8'h00}, // back to main, starts 1
    '{OP_END, 4'd15, 1'b0, KIND_HELD,  4'd0, 4'd0, 8'h00}, // level field ignored on end
    '{OP_END, 4'd0,  1'b1, KIND_ERR,   4'd0, 4'd0, 8'h00},
    '{OP_REQ, 4'd1,  1'b1, KIND_START, 4'd1, 4'd1, 8'h00}, // ladder fills the stack
    '{OP_REQ, 4'd2,  1'b1, KIND_START, 4'd2, 4'd2, 8'h00},
    '{OP_REQ, 4'd3,  1'b1, KIND_START, 4'd3, 4'd3, 8'h00},
    '{OP_REQ, 4'd4,  1'b1, KIND_START, 4'd4, 4'd4, 8'h00},
    '{OP_REQ, 4'd5,  1'b1, KIND_START, 4'd5, 4'd5, 8'h00},
    '{OP_REQ, 4'd6,  1'b1, KIND_START, 4'd6, 4'd6, 8'h00},
    '{OP_REQ, 4'd7,  1'b1, KIND_START, 4'd7, 4'd7, 8'h00},
    '{OP_REQ, 4'd8,  1'b1, KIND_START, 4'd8, 4'd8, 8'h00},
    '{OP_REQ, 4'd3,  1'b1, KIND_HELD,  4'd3, 4'd8, 8'h04},
    '{OP_END, 4'd0,  1'b0, KIND_HELD,  4'd0, 4'd0, 8'h00}  // pop with a full stack
  };

  logic clk = 1'b0;
  logic rst_n;

  pic_req_if req_if ();
  pic_evt_if evt_if ();

  priority_interrupt_controller dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .evt_o  (evt_if)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // controller shadow state
  logic [LEVELS-1:0] pend_r;
  logic [LVL_W-1:0]  prio_r;
  logic [LVL_W-1:0]  saved_r [LEVELS];
  int unsigned       depth_r;

  pic_evt_t    due_events [$];
  pic_evt_t    typed_evt;
  logic        typed_on;
  int unsigned fail_cnt;
  int unsigned evt_cnt;
  int unsigned word_cnt;
  int unsigned idle_cyc;
  int unsigned cyc_cnt;

  function automatic void queue_event(kind_e k, logic [LVL_W-1:0] l, logic lst);
    pic_evt_t e;
    int i;
    e.kind = k;
    e.lvl  = l;
    e.prio = prio_r;
    e.mask = '0;
    for (i = 0; i < MASK_W; i++) begin
      if (i < LEVELS) e.mask[i] = pend_r[i];
    end
    e.last = lst;
    due_events.push_back(e);
  endfunction

  function automatic void start_level(logic [LVL_W-1:0] l);
    if (depth_r < LEVELS) begin
      saved_r[depth_r] = prio_r;
      depth_r++;
    end
    prio_r = l;
    pend_r[l-1] = 1'b0;
  endfunction

  // returns the number of events the word causes
  function automatic int next_events(logic [OPC_W-1:0] op, logic [LVL_W-1:0] lv);
    logic [LVL_W-1:0] ended;
    int l;
    int found;
    found = 0;
    if (op == OP_REQ) begin
      if (lv == 0 || lv > LEVELS) return 0;
      pend_r[lv-1] = 1'b1;
      if (lv <= prio_r) begin
        queue_event(KIND_HELD, lv, 1'b1);
        return 1;
      end
      start_level(lv);
      queue_event(KIND_START, lv, 1'b1);
      return 1;
    end
    if (depth_r == 0) begin
      queue_event(KIND_ERR, '0, 1'b1);
      return 1;
    end
    ended = prio_r;
    depth_r--;
    prio_r = saved_r[depth_r];
    for (l = LEVELS; l > prio_r; l--) begin
      if (found == 0 && pend_r[l-1]) found = l;
    end
    if (found == 0) begin
      queue_event(KIND_END, ended, 1'b1);
      return 1;
    end
    queue_event(KIND_END, ended, 1'b0);
    start_level(found[LVL_W-1:0]);
    queue_event(KIND_START, found[LVL_W-1:0], 1'b1);
    return 2;
  endfunction

  function automatic void report_fail(string msg);
    fail_cnt++;
    $display("%0t: %s", $time, msg);
  endfunction

  function automatic void cmp_field(string fld, logic [MASK_W-1:0] e, logic [MASK_W-1:0] a);
    if (e !== a)
      report_fail($sformatf("%s mismatch, expected %0h, got %0h", fld, e, a));
  endfunction

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // prediction and checking, both at the rising edge
  always @(posedge clk) begin
    pic_evt_t want;
    int n;
    logic took;
    took = 1'b0;
    if (rst_n) begin
      cyc_cnt++;
      if (req_if.valid && req_if.ready) begin
        took = 1'b1;
        word_cnt++;
        n = next_events(req_if.opcode, req_if.level);
        if (typed_on) begin
          repeat (n) void'(due_events.pop_back());
          due_events.push_back(typed_evt);
        end
      end
      if (evt_if.valid && evt_if.ready) begin
        took = 1'b1;
        evt_cnt++;
        if (due_events.size() == 0) begin
          report_fail($sformatf("unexpected word, expected none, got kind %0d level %0d",
                                evt_if.event_kind, evt_if.event_level));
        end else begin
          want = due_events.pop_front();
          cmp_field("event_kind", MASK_W'(want.kind), MASK_W'(evt_if.event_kind));
          cmp_field("event_level", MASK_W'(want.lvl), MASK_W'(evt_if.event_level));
          cmp_field("current_priority", MASK_W'(want.prio),
                    MASK_W'(evt_if.current_priority));
          cmp_field("pending_mask", want.mask, evt_if.pending_mask);
          cmp_field("last", MASK_W'(want.last), MASK_W'(evt_if.last));
        end
      end
      idle_cyc = took ? 0 : idle_cyc + 1;
    end
  end

  // event sink: random stalls, quiet stretches, one long hold-off
  initial begin
    int unsigned stall;
    logic held;
    stall = 0;
    held = 1'b0;
    evt_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!held && evt_cnt >= HOLD_AFTER) begin
        held = 1'b1;
        stall = HOLD_CYC;
      end
      if (stall > 0) begin
        evt_if.ready <= 1'b0;
        stall--;
      end else begin
        evt_if.ready <= 1'b1;
        if (((cyc_cnt / 600) % 4) != 3 && $urandom_range(0, 99) < 30) stall = pick_gap();
      end
    end
  end

  task automatic send_word(input logic [OPC_W-1:0] op, input logic [LVL_W-1:0] lv,
                           input logic typed, input pic_evt_t e);
    int unsigned gap;
    gap = 0;
    if (((word_cnt / 150) % 4) != 3 && $urandom_range(0, 99) < 30) gap = pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.valid  <= 1'b1;
    req_if.opcode <= op;
    req_if.level  <= lv;
    typed_on  = typed;
    typed_evt = e;
    do @(posedge clk); while (!req_if.ready);
    @(negedge clk);
  endtask

  // watchdog on cycles with no word moving on either side
  initial begin
    @(posedge rst_n);
    while (idle_cyc < STALL_LIMIT) @(negedge clk);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    pic_evt_t e;
    logic [OPC_W-1:0] op;
    logic [LVL_W-1:0] lv;
    int unsigned r;
    int unsigned taken;
    int i;
    logic ramp;

    rst_n = 1'b0;
    req_if.valid  = 1'b0;
    req_if.opcode = OP_REQ;
    req_if.level  = '0;
    typed_on  = 1'b0;
    typed_evt = '0;
    pend_r  = '0;
    prio_r  = '0;
    depth_r = 0;
    for (i = 0; i < LEVELS; i++) saved_r[i] = '0;
    fail_cnt = 0;
    evt_cnt  = 0;
    word_cnt = 0;
    idle_cyc = 0;
    cyc_cnt  = 0;
    taken    = 0;

    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed table
    for (i = 0; i < DIR_N; i++) begin
      e.kind = DIR_TAB[i].kind;
      e.lvl  = DIR_TAB[i].elvl;
      e.prio = DIR_TAB[i].eprio;
      e.mask = DIR_TAB[i].emask;
      e.last = 1'b1;
      send_word(DIR_TAB[i].op, DIR_TAB[i].lvl, DIR_TAB[i].typed, e);
    end

    // random part: phases that favor requests build deep nesting, the others unwind it
    while (taken < RAND_WORDS) begin
      ramp = ((taken / 120) % 2) == 0;
      r = $urandom_range(0, 99);
      if (r < 5) begin
        op = OP_REQ;
        if ($urandom_range(0, 7) == 0) lv = '0;
        else lv = $urandom_range(LEVELS + 1, 2 ** LVL_W - 1);
      end else if (r < (ramp ? 70 : 40)) begin
        op = OP_REQ;
        lv = $urandom_range(1, LEVELS);
        taken++;
      end else begin
        op = OP_END;
        lv = $urandom_range(0, 2 ** LVL_W - 1);
        taken++;
      end
      send_word(op, lv, 1'b0, '0);
    end
    req_if.valid <= 1'b0;
    typed_on = 1'b0;

    while (due_events.size() != 0) @(negedge clk);
    repeat (DRAIN_CYC) @(negedge clk);
    if (due_events.size() != 0)
      report_fail($sformatf("%0d events never arrived", due_events.size()));

    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
